@@ rtl/core/aes128_pkg.sv @@
// AES-128 shared types, S-box and round helper functions.
// No dependencies; used by aes128_round and aes128_block_encrypt.
`default_nettype none
package aes128_pkg;

  typedef logic [127:0] block_t;

  localparam int Rounds = 10;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // byte i of the block lives at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(block_t b, int i);
    return b[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes + ShiftRows (+ MixColumns when mix is set)
  function automatic block_t round_fn(block_t s, logic mix);
    block_t t;
    block_t o;
    logic [7:0] a0, a1, a2, a3, x;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
      end
    end
    o = t;
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = get_byte(t, 4*c);
        a1 = get_byte(t, 4*c+1);
        a2 = get_byte(t, 4*c+2);
        a3 = get_byte(t, 4*c+3);
        x = a0 ^ a1 ^ a2 ^ a3;
        o[127 - 8*(4*c)   -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
        o[127 - 8*(4*c+1) -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
        o[127 - 8*(4*c+2) -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
        o[127 - 8*(4*c+3) -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    return o;
  endfunction

  function automatic block_t next_key(block_t k, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/aes128_round.sv @@
// One registered AES round stage: state round and key expansion.
// Depends on aes128_pkg.
`default_nettype none
module aes128_round #(
  parameter logic [7:0] RCON = 8'h01,
  parameter bit         LAST = 1'b0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire aes128_pkg::block_t    in_state,
  input  wire aes128_pkg::block_t    in_key,
  output logic                       out_valid,
  output aes128_pkg::block_t         out_state,
  output aes128_pkg::block_t         out_key
);
  import aes128_pkg::*;

  block_t key_next;

  assign key_next = next_key(in_key, RCON);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_key   <= key_next;
    out_state <= round_fn(in_state, !LAST) ^ key_next;
  end
endmodule
`default_nettype wire

@@ rtl/core/aes128_block_encrypt.sv @@
// AES-128 encryption, ten-round unrolled pipeline with on-the-fly key schedule.
// One block accepted every cycle (busy stays low).
// One register stage for the initial key add, then one per round.
// Synchronous reset clears valid bits and both key registers; the receiver cannot stall.
`default_nettype none
module aes128_block_encrypt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] block_high,
  input  wire logic [63:0] block_low,
  output logic             done,
  output logic [63:0]      cipher_high,
  output logic [63:0]      cipher_low,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import aes128_pkg::*;

  localparam logic [7:0] RCON [Rounds] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                          8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        accept;

  logic   v   [Rounds+1];
  block_t st  [Rounds+1];
  block_t rk  [Rounds+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= accept;
    end
    st[0] <= {block_high, block_low} ^ {key_high, key_low};
    rk[0] <= {key_high, key_low};
  end

  for (genvar g = 0; g < Rounds; g++) begin : g_round
    aes128_round #(
      .RCON (RCON[g]),
      .LAST (g == Rounds - 1)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[g]),
      .in_state  (st[g]),
      .in_key    (rk[g]),
      .out_valid (v[g+1]),
      .out_state (st[g+1]),
      .out_key   (rk[g+1])
    );
  end

  assign done        = v[Rounds];
  assign cipher_high = st[Rounds][127:64];
  assign cipher_low  = st[Rounds][63:0];

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> ##(Rounds) done) else $error("done missing after accepted block");
  a_first_valid: assert property (@(posedge clk) disable iff (rst)
    $past(accept) == v[0]) else $error("stage 0 valid mismatch");
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v[Rounds-1])) else $error("done without item in last round");
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for aes128_block_encrypt: directed vectors, then random blocks.
// Depends on aes128_pkg (register indexes) and the aes128_block_encrypt RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aes128_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        done;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  aes128_block_encrypt DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .block_high(block_high), .block_low(block_low),
    .done(done), .cipher_high(cipher_high), .cipher_low(cipher_low),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int Latency = 11;
  localparam int NumRandom = 1800;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_pair_t;

  // model copy of the key registers
  logic [63:0] key_hi_m;
  logic [63:0] key_lo_m;

  block_pair_t cipher_q[$];
  int mismatches;
  bit failed;

  // forward S-box built from GF(2^8) inverse plus affine map
  logic [7:0] sub_tab [256];

  function automatic logic [7:0] gmul2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gmul2(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  task automatic build_sub_tab();
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      sub_tab[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                   ^ 8'h63;
    end
  endtask

  function automatic block_pair_t aes_encrypt(logic [63:0] ph, logic [63:0] pl);
    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] tmp [16];
    logic [7:0] w [4];
    logic [7:0] rcon, a0, a1, a2, a3, x;
    block_pair_t res;
    rcon = 8'h01;
    for (int i = 0; i < 8; i++) begin
      st[i] = ph[63-8*i -: 8];
      st[8+i] = pl[63-8*i -: 8];
      rk[i] = key_hi_m[63-8*i -: 8];
      rk[8+i] = key_lo_m[63-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          tmp[4*c+r] = sub_tab[st[4*((c+r)%4)+r]];
      st = tmp;
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
          st[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
          st[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
          st[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
        end
      end
      w[0] = sub_tab[rk[13]] ^ rcon;
      w[1] = sub_tab[rk[14]];
      w[2] = sub_tab[rk[15]];
      w[3] = sub_tab[rk[12]];
      for (int r = 0; r < 4; r++) rk[r] ^= w[r];
      for (int j = 1; j < 4; j++)
        for (int r = 0; r < 4; r++) rk[4*j+r] ^= rk[4*(j-1)+r];
      rcon = gmul2(rcon);
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = st[i];
      res.lo[63-8*i -: 8] = st[8+i];
    end
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("[aes128_block_encrypt] ERROR");
    $finish;
  end

  // result checker
  always @(posedge clk) begin
    block_pair_t exp_c;
    if (!rst && done) begin
      if (cipher_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected cipher block %h_%h", cipher_high, cipher_low);
      end else begin
        exp_c = cipher_q.pop_front();
        if (cipher_high !== exp_c.hi || cipher_low !== exp_c.lo) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("cipher mismatch: expected %h_%h got %h_%h",
                     exp_c.hi, exp_c.lo, cipher_high, cipher_low);
        end
      end
    end
  end

  task automatic write_key(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_KEY_HIGH) key_hi_m = val;
    else if (idx == REG_KEY_LOW) key_lo_m = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  // one transfer; expected value from the model unless a typed one is given
  task automatic send_block(logic [63:0] ph, logic [63:0] pl, bit keep_high,
                            bit has_exp = 0, block_pair_t typed = '{0, 0});
    @(negedge clk);
    start <= 1'b1;
    block_high <= ph;
    block_low <= pl;
    do @(posedge clk); while (busy);
    cipher_q.push_back(has_exp ? typed : aes_encrypt(ph, pl));
    if (!keep_high) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  typedef struct {
    logic [63:0] ph;
    logic [63:0] pl;
    bit          has_exp;
    logic [63:0] eh;
    logic [63:0] el;
  } vec_t;

  vec_t zero_key_vecs[] = '{
    '{64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
    '{64'hffffffffffffffff, 64'hffffffffffffffff, 0, 64'h0, 64'h0},
    '{64'h8000000000000000, 64'h0, 0, 64'h0, 64'h0},
    '{64'h0, 64'h0000000000000001, 0, 64'h0, 64'h0},
    '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0, 64'h0, 64'h0}
  };
  vec_t fips_vecs[] = '{
    '{64'h3243f6a8885a308d, 64'h313198a2e0370734, 1, 64'h3925841d02dc09fb,
      64'hdc118597196a0b32},
    '{64'h0, 64'h0, 0, 64'h0, 64'h0},
    '{64'hffffffffffffffff, 64'hffffffffffffffff, 0, 64'h0, 64'h0}
  };

  initial begin
    int sent, burst;
    logic [63:0] kh, kl;
    rst = 1'b1;
    start = 1'b0;
    block_high = '0;
    block_low = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_KEY_HIGH;
    cfg_data = '0;
    key_hi_m = '0;
    key_lo_m = '0;
    mismatches = 0;
    failed = 1'b0;
    build_sub_tab();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // key after reset is all zeros
    foreach (zero_key_vecs[i])
      send_block(zero_key_vecs[i].ph, zero_key_vecs[i].pl, i < 2, zero_key_vecs[i].has_exp,
                 '{zero_key_vecs[i].eh, zero_key_vecs[i].el});
    wait_drained();

    write_key(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
    write_key(REG_KEY_LOW, 64'habf7158809cf4f3c);
    // write to an unused index must be ignored
    write_key(2'd3, 64'hdeadbeefdeadbeef);
    foreach (fips_vecs[i])
      send_block(fips_vecs[i].ph, fips_vecs[i].pl, 1, fips_vecs[i].has_exp,
                 '{fips_vecs[i].eh, fips_vecs[i].el});
    @(negedge clk);
    start <= 1'b0;
    wait_drained();

    write_key(REG_KEY_HIGH, 64'hffffffffffffffff);
    write_key(REG_KEY_LOW, 64'hffffffffffffffff);
    send_block(64'h0, 64'h0, 0);
    send_block(64'hffffffffffffffff, 64'hffffffffffffffff, 0);
    wait_drained();

    // random phases, each with its own key
    sent = 0;
    while (sent < NumRandom) begin
      case ($urandom_range(0, 5))
        0: begin kh = '0; kl = '0; end
        1: begin kh = '1; kl = '1; end
        default: begin kh = rand64(); kl = rand64(); end
      endcase
      write_key(REG_KEY_HIGH, kh);
      write_key(REG_KEY_LOW, kl);
      for (int n = 0; n < 300 && sent < NumRandom; ) begin
        burst = $urandom_range(1, 40);
        for (int b = 0; b < burst && sent < NumRandom; b++) begin
          send_block(($urandom_range(0, 15) == 0) ? '1 : rand64(),
                     ($urandom_range(0, 15) == 0) ? '0 : rand64(),
                     b != burst - 1 && sent != NumRandom - 1);
          sent++;
          n++;
        end
        // gap after the burst; start was already lowered
        if ($urandom_range(0, 2) != 0)
          repeat ($urandom_range(0, 15)) @(negedge clk);
        if ($urandom_range(0, 30) == 0)
          while (cipher_q.size() != 0) @(posedge clk);
      end
      wait_drained();
    end

    while (cipher_q.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
    if (!failed && cipher_q.size() == 0)
      $display("[aes128_block_encrypt] OK");
    else
      $display("[aes128_block_encrypt] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

@@ aes128_block_encrypt.f @@
rtl/core/aes128_pkg.sv
rtl/core/aes128_round.sv
rtl/core/aes128_block_encrypt.sv
tb/sv/tb.sv
